/* rtl/rgb_color_ramp_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - assertion macros
// Concurrent assertion helpers for the top-level RTL file, which checks itself.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_RAMP_SEQUENCER_MACROS_SVH
`define RGB_COLOR_RAMP_SEQUENCER_MACROS_SVH

// same-cycle implication
`define RCRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rcrs_pkg.sv */
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - package
// Widths, reset values, register indexes, phase codes and the next-phase function.
// ----------------------------------------------------------------------------
`default_nettype none

package rcrs_pkg;

    localparam int LEVEL_W       = 8;
    localparam int RAMP_W        = 15;
    localparam int STEP_W        = 8;
    localparam int PHASE_W       = 2;
    localparam int CH_N          = 3;
    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [RAMP_W-1:0]  RAMP_RESET = 15'd1000;
    localparam logic [STEP_W-1:0]  STEP_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_RED   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_GREEN = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_BLUE  = 2'd2;

    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] nxt;
        case (ph)
            PHASE_RED:   nxt = PHASE_GREEN;
            PHASE_GREEN: nxt = PHASE_BLUE;
            default:     nxt = PHASE_RED;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/rcrs_if.sv */
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - channel interfaces
// Input word, result word and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcrs_in_if;
    logic valid;
    logic ready;
    logic ms_step;

    modport source (output valid, output ms_step, input ready);
    modport sink   (input valid, input ms_step, output ready);
endinterface

interface rcrs_out_if;
    logic                              valid;
    logic                              ready;
    logic [rcrs_pkg::LEVEL_W-1:0]      red_level;
    logic [rcrs_pkg::LEVEL_W-1:0]      green_level;
    logic [rcrs_pkg::LEVEL_W-1:0]      blue_level;
    logic [rcrs_pkg::PHASE_W-1:0]      phase;
    logic                              phase_finished;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, output phase, output phase_finished,
                    input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, input phase, input phase_finished,
                    output ready);
endinterface

interface rcrs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rcrs_pkg::CFG_IDX_W-1:0]  index;
    logic [rcrs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rcrs_div.sv */
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - bit-serial divider
// Restoring divider, one quotient bit per cycle, dividend shifted out MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module rcrs_div #(
    parameter int DVD_W = rcrs_pkg::RAMP_W,
    parameter int DVS_W = rcrs_pkg::LEVEL_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], fits};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/rgb_color_ramp_sequencer.sv */
// On a mid-phase call the accepted word goes to S_EVAL, which loads the result register once it is free.
// First call of a phase: three 15-bit interval divisions run one after another
// through the shared bit-serial divider before S_EVAL.
// One word at a time; next word taken once the result is registered.
// Reset (synchronous, active low): red phase pending entry, time, levels zero,
// ramp length 1000, step size 5.
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - top level
// Ramps an RGB level red, green, blue in turn on a millisecond time base.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_color_ramp_sequencer_macros.svh"

module rgb_color_ramp_sequencer #(
    parameter int TIME_BITS = rcrs_pkg::TIME_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcrs_in_if.sink    i_in,
    rcrs_cfg_if.sink   i_cfg,
    rcrs_out_if.source o_out
);

    localparam int LW = rcrs_pkg::LEVEL_W;
    localparam int RW = rcrs_pkg::RAMP_W;
    localparam int SW = rcrs_pkg::STEP_W;
    localparam int PW = rcrs_pkg::PHASE_W;
    localparam int CN = rcrs_pkg::CH_N;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_EVAL
    } t_state;

    t_state               r_state;
    logic [1:0]           r_ch;
    logic [RW-1:0]        r_ramp;
    logic [SW-1:0]        r_step;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_phase_start;
    logic [PW-1:0]        r_phase;
    logic                 r_entry;
    logic [LW-1:0]        r_level    [CN];
    logic [TIME_BITS-1:0] r_last     [CN];
    logic [RW-1:0]        r_interval [CN];

    logic                 r_out_valid;
    logic [LW-1:0]        r_out_level [CN];
    logic [PW-1:0]        r_out_phase;
    logic                 r_out_done;

    logic                 in_acc;
    logic                 out_free;
    logic [TIME_BITS-1:0] n_now;

    logic [LW-1:0]        div_lvl;
    logic [LW-1:0]        div_dist;
    logic                 div_done;
    logic [RW-1:0]        div_quo;

    logic [LW-1:0]        n_level [CN];
    logic                 n_stepped [CN];
    logic                 n_done;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign n_now       = r_now + TIME_BITS'(i_in.ms_step);

    // distance to target: 255 - level toward full, level toward zero
    always_comb begin
        case (r_ch)
            2'd0:    div_lvl = r_level[0];
            2'd1:    div_lvl = r_level[1];
            default: div_lvl = r_level[2];
        endcase
        div_dist = (r_ch == r_phase) ? ~div_lvl : div_lvl;
    end

    rcrs_div #(
        .DVD_W (RW),
        .DVS_W (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_START),
        .i_dividend (r_ramp),
        .i_divisor  (div_dist),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        logic          up;
        logic [LW-1:0] tgt;
        logic [LW-1:0] lvl;
        logic [LW:0]   sum;
        logic          all_hit;
        logic          late;
        all_hit = 1'b1;
        for (int c = 0; c < CN; c++) begin
            up  = (r_phase == PW'(c));
            tgt = up ? rcrs_pkg::LEVEL_MAX : '0;
            lvl = (r_ramp == '0) ? tgt : r_level[c];
            sum = {1'b0, lvl} + {1'b0, r_step};
            n_stepped[c] = (lvl != tgt) &&
                           ((r_now - r_last[c]) >= TIME_BITS'(r_interval[c]));
            if (!n_stepped[c]) begin
                n_level[c] = lvl;
            end else if (up) begin
                n_level[c] = (sum > {1'b0, rcrs_pkg::LEVEL_MAX}) ?
                             rcrs_pkg::LEVEL_MAX : sum[LW-1:0];
            end else begin
                n_level[c] = (r_step >= lvl) ? '0 : LW'(lvl - r_step);
            end
            all_hit = all_hit && (n_level[c] == tgt);
        end
        late   = (r_now - r_phase_start) > TIME_BITS'(r_ramp);
        n_done = all_hit || late;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ch          <= '0;
            r_ramp        <= rcrs_pkg::RAMP_RESET;
            r_step        <= rcrs_pkg::STEP_RESET;
            r_now         <= '0;
            r_phase_start <= '0;
            r_phase       <= rcrs_pkg::PHASE_RED;
            r_entry       <= 1'b1;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < CN; c++) begin
                r_level[c] <= '0;
                r_last[c]  <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rcrs_pkg::CFG_RAMP_TIME: r_ramp <= i_cfg.data[RW-1:0];
                    rcrs_pkg::CFG_STEP_SIZE: r_step <= i_cfg.data[SW-1:0];
                    default: ;
                endcase
            end

            if (o_out.ready && (r_state != S_EVAL)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now <= n_now;
                        r_ch  <= '0;
                        if (r_entry) begin
                            r_phase_start <= n_now;
                            r_state       <= S_DIV_START;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_interval[r_ch] <= (div_dist == '0) ? '0 : div_quo;
                        if (r_ch == 2'(CN - 1)) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DIV_START;
                        end
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        for (int c = 0; c < CN; c++) begin
                            r_level[c]     <= n_level[c];
                            r_out_level[c] <= n_level[c];
                            if (n_stepped[c]) begin
                                r_last[c] <= r_now;
                            end
                        end
                        r_out_valid <= 1'b1;
                        r_out_phase <= r_phase;
                        r_out_done  <= n_done;
                        r_entry     <= n_done;
                        if (n_done) begin
                            r_phase <= rcrs_pkg::next_phase(r_phase);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.red_level      = r_out_level[0];
    assign o_out.green_level    = r_out_level[1];
    assign o_out.blue_level     = r_out_level[2];
    assign o_out.phase          = r_out_phase;
    assign o_out.phase_finished = r_out_done;

    `RCRS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in.ready, "word taken while busy")
    `RCRS_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, div_done, r_state == S_DIV_WAIT, "divider result unclaimed")
    `RCRS_ASSERT_NXT(a_eval_holds, i_clk, i_rst_n, (r_state == S_EVAL) && !out_free, (r_state == S_EVAL) && r_out_valid, "result overwritten")
    `RCRS_ASSERT_IMP(a_phase_code, i_clk, i_rst_n, 1'b1, r_phase != 2'd3, "phase out of range")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB colour ramp sequencer - testbench
// Sends millisecond call words and register writes to the sequencer. Each call
// is run through an in-bench model of the three-phase ramp, and every result
// word is checked field by field against the oldest prediction. Both sides
// idle at random, and the result side holds off for long stretches twice.
// ----------------------------------------------------------------------------

module testbench;

    localparam int TB_TIME_BITS = rcrs_pkg::TIME_BITS_DEF;
    localparam int RANDOM_CALLS = 1850;
    localparam int SETTLE_CYCLES = 60;

    typedef logic [TB_TIME_BITS-1:0] t_ms_count;

    typedef struct packed {
        logic [rcrs_pkg::LEVEL_W-1:0] red_level;
        logic [rcrs_pkg::LEVEL_W-1:0] green_level;
        logic [rcrs_pkg::LEVEL_W-1:0] blue_level;
        logic [rcrs_pkg::PHASE_W-1:0] phase;
        logic                         phase_finished;
    } t_ramp_result;

    logic i_clk;
    logic i_rst_n;

    rcrs_in_if  in_ch ();
    rcrs_out_if out_ch ();
    rcrs_cfg_if cfg_ch ();

    rgb_color_ramp_sequencer #(
        .TIME_BITS(TB_TIME_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    // model state
    logic [rcrs_pkg::RAMP_W-1:0]  ramp_ms = rcrs_pkg::RAMP_RESET;
    logic [rcrs_pkg::STEP_W-1:0]  step_size = rcrs_pkg::STEP_RESET;
    t_ms_count                    now_ms = '0;
    t_ms_count                    phase_entry_ms = '0;
    t_ms_count                    last_step_ms [rcrs_pkg::CH_N] = '{default: '0};
    logic [rcrs_pkg::LEVEL_W-1:0] level [rcrs_pkg::CH_N] = '{default: '0};
    logic [rcrs_pkg::LEVEL_W-1:0] start_level [rcrs_pkg::CH_N] = '{default: '0};
    logic [rcrs_pkg::RAMP_W-1:0]  step_interval [rcrs_pkg::CH_N] = '{default: '0};
    logic [rcrs_pkg::PHASE_W-1:0] cur_phase = rcrs_pkg::PHASE_RED;
    bit                           entering = 1'b1;

    bit           pending_calls [$];
    t_ramp_result expected_levels [$];
    int           calls_queued = 0;
    int           calls_taken = 0;
    int           levels_seen = 0;
    int           mismatches = 0;
    int           send_gap;
    int           send_quiet = 0;
    int           take_gap;
    int           take_quiet = 0;
    logic         hold_out;

    function automatic t_ramp_result predict_ramp(input logic ms_step);
        t_ramp_result                 res;
        logic [rcrs_pkg::LEVEL_W-1:0] tgt;
        logic [rcrs_pkg::LEVEL_W-1:0] span;
        int                           nxt;
        int                           ch;
        bit                           all_there;
        bit                           done;
        if (ms_step)
            now_ms = now_ms + 1'b1;
        if (entering)
            phase_entry_ms = now_ms;
        all_there = 1'b1;
        for (ch = 0; ch < rcrs_pkg::CH_N; ch++) begin
            tgt = (ch == cur_phase) ? rcrs_pkg::LEVEL_MAX : '0;
            if (entering) begin
                span = (tgt > level[ch]) ? tgt - level[ch] : level[ch] - tgt;
                start_level[ch] = level[ch];
                step_interval[ch] = (span == 0) ? '0 : rcrs_pkg::RAMP_W'(ramp_ms / span);
            end
            if (ramp_ms == 0)
                level[ch] = tgt;
            if (level[ch] != tgt &&
                    t_ms_count'(now_ms - last_step_ms[ch]) >= t_ms_count'(step_interval[ch])) begin
                last_step_ms[ch] = now_ms;
                if (tgt >= start_level[ch]) begin
                    nxt = int'(level[ch]) + int'(step_size);
                    if (nxt > int'(tgt))
                        nxt = int'(tgt);
                end else begin
                    nxt = int'(level[ch]) - int'(step_size);
                    if (step_size >= level[ch] || nxt < int'(tgt))
                        nxt = int'(tgt);
                end
                level[ch] = nxt[rcrs_pkg::LEVEL_W-1:0];
            end
            if (level[ch] != tgt)
                all_there = 1'b0;
        end
        done = all_there ||
               (t_ms_count'(now_ms - phase_entry_ms) > t_ms_count'(ramp_ms));
        res.red_level      = level[0];
        res.green_level    = level[1];
        res.blue_level     = level[2];
        res.phase          = cur_phase;
        res.phase_finished = done;
        if (done) begin
            cur_phase = (cur_phase == rcrs_pkg::PHASE_BLUE) ? rcrs_pkg::PHASE_RED :
                        cur_phase + 1'b1;
            entering  = 1'b1;
        end else begin
            entering  = 1'b0;
        end
        return res;
    endfunction

    function automatic int pick_gap(inout int quiet_left);
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [rcrs_pkg::CFG_DATA_W-1:0] pick_ramp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'd32767;
            2, 3, 4, 5: return rcrs_pkg::CFG_DATA_W'($urandom_range(1, 40));
            6, 7, 8: return rcrs_pkg::CFG_DATA_W'($urandom_range(41, 600));
            default: return rcrs_pkg::CFG_DATA_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // upper bits of a step write are don't-care, so fill them with noise
    function automatic logic [rcrs_pkg::CFG_DATA_W-1:0] pick_step();
        logic [rcrs_pkg::STEP_W-1:0] step;
        case ($urandom_range(0, 15))
            0:       step = '0;
            1, 2:    step = 8'd255;
            3, 4:    step = 8'd1;
            default: step = rcrs_pkg::STEP_W'($urandom_range(1, 255));
        endcase
        return {(rcrs_pkg::CFG_DATA_W - rcrs_pkg::STEP_W)'($urandom), step};
    endfunction

    task automatic write_register(input logic [rcrs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rcrs_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == rcrs_pkg::CFG_RAMP_TIME)
            ramp_ms = value[rcrs_pkg::RAMP_W-1:0];
        else if (idx == rcrs_pkg::CFG_STEP_SIZE)
            step_size = value[rcrs_pkg::STEP_W-1:0];
    endtask

    task automatic queue_call(input bit ms_step);
        pending_calls.push_back(ms_step);
        calls_queued++;
    endtask

    // bits are sent LSB first
    task automatic queue_pattern(input logic [7:0] pattern, input int count);
        int k;
        for (k = 0; k < count; k++)
            queue_call(pattern[k]);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (calls_taken != calls_queued || expected_levels.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_500_000;
        $display("rgb_color_ramp_sequencer test failed");
        $finish;
    end

    // long result-side hold-offs while calls keep coming
    initial begin
        hold_out = 1'b0;
        wait (levels_seen >= 400);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_out <= 1'b0;
        wait (levels_seen >= 1300);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (500) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    // call word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.ms_step <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_levels.push_back(predict_ramp(in_ch.ms_step));
                calls_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_calls.size() != 0) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.ms_step <= pending_calls.pop_front();
                    send_gap = pick_gap(send_quiet);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result word monitor
    always @(posedge i_clk) begin : result_check
        t_ramp_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                levels_seen++;
                if (expected_levels.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_levels.pop_front();
                    check_field("red_level", want.red_level, out_ch.red_level);
                    check_field("green_level", want.green_level, out_ch.green_level);
                    check_field("blue_level", want.blue_level, out_ch.blue_level);
                    check_field("phase", 8'(want.phase), 8'(out_ch.phase));
                    check_field("phase_finished", 8'(want.phase_finished),
                                8'(out_ch.phase_finished));
                end
            end
            if (hold_out) begin
                out_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                take_gap = pick_gap(take_quiet);
            end
        end
    end

    initial begin : stimulus
        int n;
        int density;
        int random_sent;
        i_rst_n       = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = rcrs_pkg::CFG_RAMP_TIME;
        cfg_ch.data   = '0;
        random_sent   = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, repeated and advancing calls
        queue_pattern(8'b10110, 5);
        wait_idle();
        // zero ramp time: snap and finish on every call, all three phases
        write_register(rcrs_pkg::CFG_RAMP_TIME, '0);
        queue_pattern(8'b010, 3);
        wait_idle();
        // zero step: phase ends only on timeout
        write_register(rcrs_pkg::CFG_STEP_SIZE, {7'h7f, 8'd0});
        write_register(rcrs_pkg::CFG_RAMP_TIME, 15'd2);
        queue_pattern(8'b1111, 4);
        wait_idle();
        // register maxima, then the same step with a tiny ramp time
        write_register(rcrs_pkg::CFG_RAMP_TIME, 15'd32767);
        write_register(rcrs_pkg::CFG_STEP_SIZE, 15'd255);
        queue_pattern(8'b1011, 4);
        wait_idle();
        write_register(rcrs_pkg::CFG_RAMP_TIME, 15'd1);
        queue_pattern(8'b111, 3);
        wait_idle();
        write_register(rcrs_pkg::CFG_RAMP_TIME, 15'd10);
        write_register(rcrs_pkg::CFG_STEP_SIZE, 15'd1);
        queue_pattern(8'b1101, 4);
        wait_idle();

        while (random_sent < RANDOM_CALLS) begin
            n       = $urandom_range(60, 200);
            density = $urandom_range(40, 95);
            if (n > RANDOM_CALLS - random_sent)
                n = RANDOM_CALLS - random_sent;
            if ($urandom_range(0, 3) != 0)
                write_register(rcrs_pkg::CFG_RAMP_TIME, pick_ramp());
            if ($urandom_range(0, 3) != 0)
                write_register(rcrs_pkg::CFG_STEP_SIZE, pick_step());
            repeat (n) queue_call($urandom_range(0, 99) < density);
            random_sent += n;
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("rgb_color_ramp_sequencer test passed");
        else
            $display("rgb_color_ramp_sequencer test failed");
        $finish;
    end

endmodule
